// File: rtl/core/fsa_pkg.sv
// ============================================================================
// fsa_pkg
// Shared types, codes and the control store of the sector allocator.
// ============================================================================
package fsa_pkg;

    localparam int SECTOR_W = 12;
    localparam int COUNT_W  = 13;
    localparam int ENTRY_W  = 14;

    // request kinds
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // table entry codes
    localparam logic [1:0] CODE_LINK = 2'd0;
    localparam logic [1:0] CODE_FREE = 2'd1;
    localparam logic [1:0] CODE_LAST = 2'd2;
    localparam logic [1:0] CODE_BAD  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_CHAIN = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    // control store addresses
    typedef enum logic [3:0] {
        U_IDLE     = 4'd0,
        U_CLEAR    = 4'd1,
        U_AL_START = 4'd2,
        U_AL_SCAN  = 4'd3,
        U_FULL     = 4'd4,
        U_CLAIM    = 4'd5,
        U_FR_START = 4'd6,
        U_FR_WALK  = 4'd7,
        U_BAD      = 4'd8,
        U_WRITE    = 4'd9,
        U_DONE     = 4'd10
    } upc_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_CLEAR,
        OP_AL_START,
        OP_AL_STEP,
        OP_FULL,
        OP_CLAIM,
        OP_FR_START,
        OP_FR_STEP,
        OP_BAD,
        OP_WRITE,
        OP_RESULT
    } op_t;

    // branch conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_CNT_ZERO,
        C_DATA_FREE,
        C_MORE,
        C_S_OUT,
        C_WALK_END,
        C_WALK_GO,
        C_CLR_END,
        C_OUT_FREE
    } cond_t;

    // one control word
    typedef struct packed {
        op_t   op;
        cond_t jmp_cond;
        upc_t  jmp_target;
        cond_t stay_cond;
        logic  dispatch;
    } uword_t;

    // sequencer to datapath
    typedef struct packed {
        op_t  op;
        logic accept;
    } ctl_t;

    // datapath to sequencer
    typedef struct packed {
        logic cnt_zero;
        logic data_free;
        logic more;
        logic s_out;
        logic walk_end;
        logic walk_go;
        logic clr_end;
        logic out_free;
    } flags_t;

    function automatic logic [ENTRY_W-1:0] make_entry(logic [1:0] code,
                                                      logic [SECTOR_W-1:0] nxt);
        return {code, nxt};
    endfunction

    // control store
    function automatic uword_t ucode(upc_t step);
        uword_t w;
        unique case (step)
            U_IDLE:     w = '{op: OP_ACCEPT,   jmp_cond: C_NEVER,    jmp_target: U_IDLE,
                              stay_cond: C_ALWAYS, dispatch: 1'b1};
            U_CLEAR:    w = '{op: OP_CLEAR,    jmp_cond: C_CLR_END,  jmp_target: U_IDLE,
                              stay_cond: C_ALWAYS, dispatch: 1'b0};
            U_AL_START: w = '{op: OP_AL_START, jmp_cond: C_CNT_ZERO, jmp_target: U_FULL,
                              stay_cond: C_NEVER,  dispatch: 1'b0};
            U_AL_SCAN:  w = '{op: OP_AL_STEP,  jmp_cond: C_DATA_FREE, jmp_target: U_CLAIM,
                              stay_cond: C_MORE,   dispatch: 1'b0};
            U_FULL:     w = '{op: OP_FULL,     jmp_cond: C_ALWAYS,   jmp_target: U_DONE,
                              stay_cond: C_NEVER,  dispatch: 1'b0};
            U_CLAIM:    w = '{op: OP_CLAIM,    jmp_cond: C_ALWAYS,   jmp_target: U_DONE,
                              stay_cond: C_NEVER,  dispatch: 1'b0};
            U_FR_START: w = '{op: OP_FR_START, jmp_cond: C_S_OUT,    jmp_target: U_BAD,
                              stay_cond: C_NEVER,  dispatch: 1'b0};
            U_FR_WALK:  w = '{op: OP_FR_STEP,  jmp_cond: C_WALK_END, jmp_target: U_DONE,
                              stay_cond: C_WALK_GO, dispatch: 1'b0};
            U_BAD:      w = '{op: OP_BAD,      jmp_cond: C_ALWAYS,   jmp_target: U_DONE,
                              stay_cond: C_NEVER,  dispatch: 1'b0};
            U_WRITE:    w = '{op: OP_WRITE,    jmp_cond: C_ALWAYS,   jmp_target: U_DONE,
                              stay_cond: C_NEVER,  dispatch: 1'b0};
            U_DONE:     w = '{op: OP_RESULT,   jmp_cond: C_OUT_FREE, jmp_target: U_IDLE,
                              stay_cond: C_ALWAYS, dispatch: 1'b0};
            default:    w = '{op: OP_ACCEPT,   jmp_cond: C_ALWAYS,   jmp_target: U_IDLE,
                              stay_cond: C_NEVER,  dispatch: 1'b0};
        endcase
        return w;
    endfunction

    // entry point of each request kind
    function automatic upc_t dispatch_target(logic [1:0] kind);
        upc_t t;
        unique case (kind)
            KIND_ALLOC: t = U_AL_START;
            KIND_FREE:  t = U_FR_START;
            KIND_WRITE: t = U_WRITE;
            default:    t = U_DONE;
        endcase
        return t;
    endfunction

    // condition select
    function automatic logic cond_true(cond_t c, flags_t f);
        logic r;
        unique case (c)
            C_NEVER:     r = 1'b0;
            C_ALWAYS:    r = 1'b1;
            C_CNT_ZERO:  r = f.cnt_zero;
            C_DATA_FREE: r = f.data_free;
            C_MORE:      r = f.more;
            C_S_OUT:     r = f.s_out;
            C_WALK_END:  r = f.walk_end;
            C_WALK_GO:   r = f.walk_go;
            C_CLR_END:   r = f.clr_end;
            C_OUT_FREE:  r = f.out_free;
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/fsa_ram.sv
// ============================================================================
// fsa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module fsa_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read, read-before-write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/fsa_datapath.sv
// ============================================================================
// fsa_datapath
// Pointer, walk counter, sector table and result register of the allocator.
// ============================================================================
module fsa_datapath #(
    parameter int MAX_SECTORS = 4096
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fsa_pkg::ctl_t           ctl,
    output fsa_pkg::flags_t         flags,
    input  logic                    cfg_we,
    input  logic [12:0]             cfg_data,
    input  logic [11:0]             sector,
    input  logic [1:0]              entry_code,
    input  logic [11:0]             entry_next,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [11:0]             found_sector,
    output logic [1:0]              status,
    output logic [12:0]             freed_count
);

    import fsa_pkg::*;

    localparam int AW = $clog2(MAX_SECTORS);
    localparam logic [16:0] MAX_W = 17'(MAX_SECTORS);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_SECTORS - 1);

    // control registers
    logic [COUNT_W-1:0]  sc_reg, sc_next;
    logic [SECTOR_W-1:0] ptr_reg, ptr_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                out_valid_reg, out_valid_next;
    logic                byp_reg, byp_next;

    // working registers
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    logic [1:0]          code_reg, code_next;
    logic [SECTOR_W-1:0] link_reg, link_next;
    logic [SECTOR_W-1:0] cur_reg, cur_next;
    logic [COUNT_W-1:0]  walk_reg, walk_next;
    logic [1:0]          status_reg, status_next;
    logic [SECTOR_W-1:0] found_reg, found_next;
    logic [ENTRY_W-1:0]  byp_data_reg, byp_data_next;
    logic [SECTOR_W-1:0] out_found_reg, out_found_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic [COUNT_W-1:0]  out_freed_reg, out_freed_next;

    // table port
    logic                ram_we;
    logic                wr_use_clr;
    logic [SECTOR_W-1:0] wr_sel;
    logic [SECTOR_W-1:0] rd_sel;
    logic [16:0]         wr_wide;
    logic [16:0]         rd_wide;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [ENTRY_W-1:0]  ent;

    // derived values
    logic [16:0]         sc_wide;
    logic [16:0]         cnt_wide;
    logic [COUNT_W-1:0]  cnt;
    logic [COUNT_W-1:0]  scan_inc;
    logic [SECTOR_W-1:0] scan_wrap;
    logic [SECTOR_W-1:0] ptr_wrap;
    logic                n_lt;
    logic                is_link;
    logic                next_out;
    logic                sector_in_table;
    logic                out_free;

    // live sector count, saturated at the table depth
    assign sc_wide  = {4'b0, sc_reg};
    assign cnt_wide = (sc_wide > MAX_W) ? MAX_W : sc_wide;
    assign cnt      = cnt_wide[COUNT_W-1:0];

    // table entry with same-cycle write forwarding
    assign ent      = byp_reg ? byp_data_reg : ram_rdata;
    assign is_link  = (ent[13:12] == CODE_LINK);
    assign next_out = ({1'b0, ent[11:0]} >= cnt);
    assign n_lt     = (walk_reg < cnt);

    // next-fit scan arithmetic
    assign scan_inc  = {1'b0, cur_reg} + 13'd1;
    assign scan_wrap = (scan_inc >= cnt) ? '0 : scan_inc[SECTOR_W-1:0];
    assign ptr_wrap  = ({1'b0, ptr_reg} >= cnt) ? '0 : ptr_reg;

    assign sector_in_table = ({5'b0, sector_reg} < MAX_W);
    assign out_free        = !(out_valid_reg && out_stall);

    // flags to the sequencer
    assign flags.cnt_zero  = (cnt == '0);
    assign flags.data_free = (ent[13:12] == CODE_FREE);
    assign flags.more      = (({1'b0, walk_reg} + 14'd1) < {1'b0, cnt});
    assign flags.s_out     = ({1'b0, sector_reg} >= cnt);
    assign flags.walk_end  = flags.data_free || (n_lt && !is_link);
    assign flags.walk_go   = !flags.data_free && n_lt && is_link && !next_out;
    assign flags.clr_end   = (clr_reg == CLR_LAST);
    assign flags.out_free  = out_free;

    // address conversion to the table width
    assign wr_wide = {5'b0, wr_sel};
    assign rd_wide = {5'b0, rd_sel};
    assign wr_addr = wr_use_clr ? clr_reg : wr_wide[AW-1:0];
    assign rd_addr = rd_wide[AW-1:0];

    // operation decode
    always_comb
    begin
        sc_next         = sc_reg;
        ptr_next        = ptr_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg;
        sector_next     = sector_reg;
        code_next       = code_reg;
        link_next       = link_reg;
        cur_next        = cur_reg;
        walk_next       = walk_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_freed_next  = out_freed_reg;
        ram_we          = 1'b0;
        wr_use_clr      = 1'b0;
        wr_sel          = cur_reg;
        wr_data         = make_entry(CODE_FREE, '0);
        rd_sel          = cur_reg;

        if (cfg_we)
        begin
            sc_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (ctl.op)
            OP_ACCEPT:
            begin
                if (ctl.accept)
                begin
                    sector_next = sector;
                    code_next   = entry_code;
                    link_next   = entry_next;
                    status_next = ST_OK;
                    found_next  = '0;
                    walk_next   = '0;
                end
            end
            OP_CLEAR:
            begin
                ram_we     = 1'b1;
                wr_use_clr = 1'b1;
                if (!flags.clr_end)
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            OP_AL_START:
            begin
                cur_next  = ptr_wrap;
                walk_next = '0;
                rd_sel    = ptr_wrap;
            end
            OP_AL_STEP:
            begin
                if (!flags.data_free)
                begin
                    cur_next  = scan_wrap;
                    walk_next = walk_reg + 13'd1;
                    rd_sel    = scan_wrap;
                end
            end
            OP_FULL:
            begin
                status_next = ST_FULL;
                found_next  = '0;
                walk_next   = '0;
            end
            OP_CLAIM:
            begin
                ram_we     = 1'b1;
                wr_data    = make_entry(CODE_LAST, '0);
                ptr_next   = cur_reg;
                found_next = cur_reg;
                walk_next  = '0;
            end
            OP_FR_START:
            begin
                cur_next  = sector_reg;
                walk_next = '0;
                rd_sel    = sector_reg;
            end
            OP_FR_STEP:
            begin
                if (!flags.data_free && n_lt)
                begin
                    ram_we    = 1'b1;
                    walk_next = walk_reg + 13'd1;
                    cur_next  = ent[11:0];
                    rd_sel    = ent[11:0];
                end
            end
            OP_BAD:
            begin
                status_next = ST_CHAIN;
            end
            OP_WRITE:
            begin
                wr_sel  = sector_reg;
                wr_data = make_entry(code_reg, (code_reg == CODE_LINK) ? link_reg : '0);
                ram_we  = sector_in_table && (code_reg != CODE_BAD);
            end
            OP_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_status_next = status_reg;
                    out_freed_next  = walk_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // forward a write that hits the address read in the same cycle
    assign byp_next      = ram_we && (wr_addr == rd_addr);
    assign byp_data_next = wr_data;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg        <= COUNT_RESET;
            ptr_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            sc_reg        <= sc_next;
            ptr_reg       <= ptr_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            byp_reg       <= byp_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        sector_reg     <= sector_next;
        code_reg       <= code_next;
        link_reg       <= link_next;
        cur_reg        <= cur_next;
        walk_reg       <= walk_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        byp_data_reg   <= byp_data_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_freed_reg  <= out_freed_next;
    end

    // sector table
    fsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SECTORS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign found_sector = out_found_reg;
    assign status       = out_status_reg;
    assign freed_count  = out_freed_reg;

    // chain walk never frees more sectors than are in use
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_FR_STEP) |-> (walk_reg <= cnt))
        else $error("free walk count beyond sector count");

    // a claimed sector lies inside the live range
    a_claim_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_CLAIM) |-> ({1'b0, cur_reg} < cnt))
        else $error("claimed sector outside live range");

    // the allocate scan only reads the table
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_AL_STEP || ctl.op == OP_AL_START) |-> !ram_we)
        else $error("table written during allocate scan");

endmodule

// File: rtl/core/fsa_sequencer.sv
// ============================================================================
// fsa_sequencer
// Step counter over the control store, with dispatch and conditional jumps.
// ============================================================================
module fsa_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      kind,
    input  fsa_pkg::flags_t flags,
    output fsa_pkg::ctl_t   ctl
);

    import fsa_pkg::*;

    upc_t   upc_reg, upc_next;
    uword_t word;
    logic   accept;

    // fetch the current control word
    assign word   = ucode(upc_reg);
    assign accept = in_valid && word.dispatch;

    // next step select
    always_comb
    begin
        if (accept)
        begin
            upc_next = dispatch_target(kind);
        end
        else if (cond_true(word.jmp_cond, flags))
        begin
            upc_next = word.jmp_target;
        end
        else if (cond_true(word.stay_cond, flags))
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = upc_t'(upc_reg + 4'd1);
        end
    end

    // step counter, table clear runs first after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign in_stall   = !word.dispatch;
    assign ctl.op     = word.op;
    assign ctl.accept = accept;

    // the table clear is never re-entered once left
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg != U_CLEAR) |=> (upc_reg != U_CLEAR))
        else $error("sequencer returned to table clear");

    // an accepted request always starts a program
    a_dispatch_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept |=> (upc_reg != U_IDLE))
        else $error("accepted request did not leave idle");

endmodule

// File: rtl/core/fat_sector_allocator.sv
// ============================================================================
// fat_sector_allocator
// FAT-style sector table with next-fit allocate, chain free and entry load.
// ============================================================================
//
//  channel   direction  handshake             fields
//  in        to block   in_valid / in_stall   kind, sector, entry_code, entry_next
//  out       from block out_valid / out_stall found_sector, status, freed_count
//  cfg       to block   cfg_we                cfg_data (sector_count)
//
//  Allocate inspects sectors from the search pointer, at most the count of them.
//  Free walks the sectors of the chain; write loads one table entry.
//  Every table entry visited is read through the single read port of the table RAM.
//  After reset the table is swept to free while in_stall is high.
//  A new request is taken while a result still waits on out_stall.
//
module fat_sector_allocator #(
    parameter int MAX_SECTORS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [11:0] sector,
    input  logic [1:0]  entry_code,
    input  logic [11:0] entry_next,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] found_sector,
    output logic [1:0]  status,
    output logic [12:0] freed_count
);

    import fsa_pkg::*;

    ctl_t   ctl;
    flags_t flags;

    // control sequencer
    fsa_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .flags    (flags),
        .ctl      (ctl)
    );

    // datapath with sector table
    fsa_datapath #(
        .MAX_SECTORS (MAX_SECTORS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .flags        (flags),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .sector       (sector),
        .entry_code   (entry_code),
        .entry_next   (entry_next),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found_sector (found_sector),
        .status       (status),
        .freed_count  (freed_count)
    );

endmodule

// File: dv/fat_sector_allocator_checker.sv
// ============================================================================
// fat_sector_allocator_checker
// Watches the request, result and register ports of the sector allocator,
// keeps its own copy of the sector map, search pointer and sector count,
// predicts the result of every accepted request and compares each accepted
// result field by field against the oldest prediction.
// ============================================================================
`timescale 1ns / 100ps

module fat_sector_allocator_checker #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fsa_pkg::COUNT_W-1:0] cfg_data,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [1:0]                  kind,
    input  logic [fsa_pkg::SECTOR_W-1:0] sector,
    input  logic [1:0]                  entry_code,
    input  logic [fsa_pkg::SECTOR_W-1:0] entry_next,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [fsa_pkg::SECTOR_W-1:0] found_sector,
    input  logic [1:0]                  status,
    input  logic [fsa_pkg::COUNT_W-1:0] freed_count,
    output int                          errors,
    output int                          pending
);

    import fsa_pkg::*;

    // one predicted result
    typedef struct {
        logic [SECTOR_W-1:0] found;
        logic [1:0]          status;
        logic [COUNT_W-1:0]  freed;
    } alloc_outcome_t;

    // shadow of the block state
    logic [ENTRY_W-1:0]  sector_map [0:TABLE_SIZE-1];
    logic [SECTOR_W-1:0] search_ptr;
    logic [COUNT_W-1:0]  sector_count;

    alloc_outcome_t outcomes_due [$];
    alloc_outcome_t want;
    int             idx;

    task automatic report(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // apply one request to the shadow state and return its result
    function automatic alloc_outcome_t predict_request(logic [1:0] k,
                                                       logic [SECTOR_W-1:0] s,
                                                       logic [1:0] c,
                                                       logic [SECTOR_W-1:0] nx);
        alloc_outcome_t      r;
        int unsigned         live;
        int unsigned         p;
        int unsigned         n;
        int unsigned         walk;
        logic [ENTRY_W-1:0]  ent;
        logic [1:0]          code;
        bit                  done;
        r.found  = '0;
        r.status = ST_OK;
        r.freed  = '0;
        // counts above the table size saturate
        live = (sector_count > TABLE_SIZE) ? TABLE_SIZE : sector_count;
        case (k)
            KIND_ALLOC:
            begin
                // next-fit scan from the pointer, wrapping at the count
                r.status = ST_FULL;
                p = search_ptr;
                for (int i = 0; i < live; i++)
                begin
                    if (p >= live)
                        p = 0;
                    if (sector_map[p][ENTRY_W-1:SECTOR_W] == CODE_FREE)
                    begin
                        sector_map[p] = {CODE_LAST, {SECTOR_W{1'b0}}};
                        search_ptr    = SECTOR_W'(p);
                        r.found       = SECTOR_W'(p);
                        r.status      = ST_OK;
                        break;
                    end
                    p++;
                end
            end
            KIND_FREE:
            begin
                // follow the chain, freeing up to and including the last entry
                walk = s;
                n    = 0;
                done = 1'b0;
                while (!done)
                begin
                    if (walk >= live)
                    begin
                        r.status = ST_CHAIN;
                        done     = 1'b1;
                    end
                    else
                    begin
                        ent  = sector_map[walk];
                        code = ent[ENTRY_W-1:SECTOR_W];
                        if (code == CODE_FREE)
                            done = 1'b1;
                        else if (n >= live)
                        begin
                            r.status = ST_CHAIN;
                            done     = 1'b1;
                        end
                        else
                        begin
                            sector_map[walk] = {CODE_FREE, {SECTOR_W{1'b0}}};
                            n++;
                            if (code != CODE_LINK)
                                done = 1'b1;
                            else
                                walk = ent[SECTOR_W-1:0];
                        end
                    end
                end
                r.freed = COUNT_W'(n);
            end
            KIND_WRITE:
            begin
                // bad codes and indexes past the table are dropped
                if (s < TABLE_SIZE && c != CODE_BAD)
                    sector_map[s] = {c, (c == CODE_LINK) ? nx : {SECTOR_W{1'b0}}};
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // sample all channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (idx = 0; idx < TABLE_SIZE; idx++)
                sector_map[idx] = {CODE_FREE, {SECTOR_W{1'b0}}};
            search_ptr   = '0;
            sector_count = COUNT_RESET;
            outcomes_due.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // result side first, so a stray result never meets a fresh prediction
            if (out_valid && !out_stall)
            begin
                if (outcomes_due.size() == 0)
                    report($sformatf(
                        "result with nothing outstanding: sector %0d status %0d freed %0d",
                        found_sector, status, freed_count));
                else
                begin
                    want = outcomes_due.pop_front();
                    if (found_sector !== want.found)
                        report($sformatf("found_sector %0d, predicted %0d",
                                         found_sector, want.found));
                    if (status !== want.status)
                        report($sformatf("status %0d, predicted %0d", status, want.status));
                    if (freed_count !== want.freed)
                        report($sformatf("freed_count %0d, predicted %0d",
                                         freed_count, want.freed));
                end
            end
            if (cfg_we)
                sector_count = cfg_data;
            if (in_valid && !in_stall)
                outcomes_due.push_back(predict_request(kind, sector, entry_code, entry_next));
            pending = outcomes_due.size();
        end
    end

endmodule

// File: dv/fat_sector_allocator_tb.sv
// ============================================================================
// fat_sector_allocator_tb
// Drives the sector allocator with a directed sequence covering saturated,
// zero and single-sector counts, cyclic and out-of-range chains and ignored
// writes, then with random request mixes built mostly from link/last chains
// that are freed again, over several sector counts and idle/stall patterns.
// Checking is done by the checker instantiated beside the block.
// ============================================================================
`timescale 1ns / 100ps

module fat_sector_allocator_tb;
    import fsa_pkg::*;

    localparam int         TABLE_SIZE = 4096;
    // request kind the block answers without doing anything
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_we       = 1'b0;
    logic [COUNT_W-1:0]  cfg_data     = '0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [1:0]          kind         = KIND_ALLOC;
    logic [SECTOR_W-1:0] sector       = '0;
    logic [1:0]          entry_code   = CODE_LINK;
    logic [SECTOR_W-1:0] entry_next   = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [SECTOR_W-1:0] found_sector;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  freed_count;

    int errors;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int cur_count = TABLE_SIZE;

    fat_sector_allocator #(
        .MAX_SECTORS(TABLE_SIZE)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .sector(sector),
        .entry_code(entry_code),
        .entry_next(entry_next),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found_sector(found_sector),
        .status(status),
        .freed_count(freed_count)
    );

    fat_sector_allocator_checker #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .sector(sector),
        .entry_code(entry_code),
        .entry_next(entry_next),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found_sector(found_sector),
        .status(status),
        .freed_count(freed_count),
        .errors(errors),
        .pending(pending)
    );

    always #5 clk = ~clk;

    // random back-pressure on the result side
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // hard stop, well beyond the slowest legal run (table clear, the requests
    // with their scans and chain walks, plus idle and stall gaps)
    initial
    begin
        #50ms;
        $display("fat_sector_allocator verification failed");
        $finish;
    end

    // present one request and hold it until taken; returns on the accepting edge
    task issue_request(input logic [1:0] k, input logic [SECTOR_W-1:0] s,
                       input logic [1:0] c, input logic [SECTOR_W-1:0] nx);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        sector     <= s;
        entry_code <= c;
        entry_next <= nx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop sending and wait for every outstanding result
    task wait_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // register write with the block idle
    task set_sector_count(input logic [COUNT_W-1:0] v);
        wait_idle();
        // give the result path time to fall back to idle
        repeat (8) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_count = v;
    endtask

    // mostly inside a small window of the live sectors, sometimes anywhere
    function automatic logic [SECTOR_W-1:0] pick_sector();
        int span;
        span = (cur_count == 0) ? 1 : ((cur_count > 64) ? 64 : cur_count);
        if ($urandom_range(0, 9) == 0)
            return SECTOR_W'($urandom());
        return SECTOR_W'($urandom_range(0, span - 1));
    endfunction

    // random mix, mostly chains that are built and then freed
    task random_requests(input int n);
        int                  sent;
        int                  r;
        int                  len;
        logic [SECTOR_W-1:0] links [0:5];
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                issue_request(KIND_ALLOC, SECTOR_W'($urandom()), 2'($urandom()),
                              SECTOR_W'($urandom()));
                sent++;
            end
            else if (r < 45)
            begin
                issue_request(KIND_FREE, pick_sector(), 2'($urandom()),
                              SECTOR_W'($urandom()));
                sent++;
            end
            else if (r < 68)
            begin
                issue_request(KIND_WRITE, pick_sector(), 2'($urandom_range(0, 3)),
                              pick_sector());
                sent++;
            end
            else if (r < 94)
            begin
                // link chain ending in a last entry, then free it from the head
                len = $urandom_range(2, 5);
                for (int i = 0; i < len; i++)
                    links[i] = pick_sector();
                for (int i = 0; i < len - 1; i++)
                    issue_request(KIND_WRITE, links[i], CODE_LINK, links[i+1]);
                issue_request(KIND_WRITE, links[len-1], CODE_LAST, SECTOR_W'($urandom()));
                issue_request(KIND_FREE, links[0], 2'($urandom()), SECTOR_W'($urandom()));
                sent += len + 1;
            end
            else
            begin
                issue_request(KIND_SPARE, SECTOR_W'($urandom()), 2'($urandom()),
                              SECTOR_W'($urandom()));
                sent++;
            end
        end
    endtask

    initial
    begin
        // reset, then wait out the table clearing pass
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);

        // saturated count
        set_sector_count(13'd8191);
        issue_request(KIND_ALLOC, 12'd0, CODE_LINK, 12'd0);
        issue_request(KIND_ALLOC, 12'd4095, CODE_BAD, 12'd4095);
        issue_request(KIND_WRITE, 12'd2, CODE_LAST, 12'd4095);
        issue_request(KIND_WRITE, 12'd4095, CODE_LINK, 12'd2);
        issue_request(KIND_FREE, 12'd4095, CODE_LINK, 12'd0);
        issue_request(KIND_FREE, 12'd0, CODE_LINK, 12'd0);
        // free on an entry that is already free
        issue_request(KIND_FREE, 12'd0, CODE_LINK, 12'd0);
        // bad entry code and spare kind are ignored
        issue_request(KIND_WRITE, 12'd5, CODE_BAD, 12'd4095);
        issue_request(KIND_SPARE, 12'd4095, CODE_BAD, 12'd4095);
        issue_request(KIND_WRITE, 12'd1, CODE_LINK, 12'd4095);
        issue_request(KIND_FREE, 12'd1, CODE_FREE, 12'd0);

        // no sectors at all
        set_sector_count(13'd0);
        issue_request(KIND_ALLOC, 12'd0, CODE_LINK, 12'd0);
        issue_request(KIND_FREE, 12'd0, CODE_LINK, 12'd0);
        issue_request(KIND_WRITE, 12'd3, CODE_LINK, 12'd7);

        // cyclic chain over all four sectors, then a chain leaving the range
        set_sector_count(13'd4);
        issue_request(KIND_WRITE, 12'd0, CODE_LINK, 12'd1);
        issue_request(KIND_WRITE, 12'd1, CODE_LINK, 12'd2);
        issue_request(KIND_WRITE, 12'd2, CODE_LINK, 12'd3);
        issue_request(KIND_WRITE, 12'd3, CODE_LINK, 12'd0);
        issue_request(KIND_FREE, 12'd2, CODE_LINK, 12'd0);
        issue_request(KIND_WRITE, 12'd3, CODE_LINK, 12'd9);
        issue_request(KIND_WRITE, 12'd2, CODE_LINK, 12'd3);
        issue_request(KIND_FREE, 12'd2, CODE_LINK, 12'd0);
        issue_request(KIND_ALLOC, 12'd0, CODE_LINK, 12'd0);

        // single sector: pointer wraps, then the disk is full
        set_sector_count(13'd1);
        issue_request(KIND_ALLOC, 12'd0, CODE_LINK, 12'd0);
        issue_request(KIND_ALLOC, 12'd0, CODE_LINK, 12'd0);

        // random phases over counts and idle/stall patterns
        set_sector_count(13'd48);
        idle_pct  = 0;
        stall_pct = 0;
        random_requests(24);

        set_sector_count(13'd12);
        idle_pct  = 63;
        stall_pct = 0;
        random_requests(24);

        set_sector_count(13'd4096);
        idle_pct  = 0;
        stall_pct = 63;
        random_requests(20);

        set_sector_count(13'd3);
        idle_pct  = 24;
        stall_pct = 24;
        random_requests(10);
        // hold off until the block has answered everything
        wait_idle();
        random_requests(10);

        set_sector_count(13'd4095);
        idle_pct  = 0;
        stall_pct = 0;
        random_requests(24);

        // drain and let any stray result show up
        wait_idle();
        stall_pct = 0;
        repeat (64) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("fat_sector_allocator verification clean");
        else
            $display("fat_sector_allocator verification failed");
        $finish;
    end

endmodule
